@@ src/cau_pkg.sv @@
// Shared constants, types and helper functions for the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;
   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 20;
   localparam int ANG_FRAC     = 30;
   localparam int CORDIC_PRE   = 28;
   localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;
   localparam int QBITS        = 32 + FRAC_BITS;
   localparam int DIV_LAT      = QBITS + 2;
   localparam int ROOT_STEPS   = 32;
   localparam int SQRT_LAT     = ROOT_STEPS + 2;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

   localparam logic [35:0] PI_Q30  = 36'd3373259426;
   localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
   localparam logic [31:0] MIN_NEG = 32'h8000_0000;

   localparam logic [2:0] KIND_ADD   = 3'd0;
   localparam logic [2:0] KIND_SUB   = 3'd1;
   localparam logic [2:0] KIND_MUL   = 3'd2;
   localparam logic [2:0] KIND_DIV   = 3'd3;
   localparam logic [2:0] KIND_EQUAL = 3'd4;
   localparam logic [2:0] KIND_LESS  = 3'd5;
   localparam logic [2:0] KIND_MAG   = 3'd6;
   localparam logic [2:0] KIND_PHASE = 3'd7;

   typedef struct packed {
      logic        err;
      logic [31:0] val;
   } sat_type;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        flag;
      logic        err;
   } res_type;

   typedef struct packed {
      logic               valid;
      logic [2:0]         kind;
      logic signed [31:0] ar;
      logic signed [31:0] ai;
      logic signed [64:0] mre;
      logic signed [64:0] mim;
      logic signed [64:0] nre;
      logic signed [64:0] nim;
      logic [63:0]        d;
      res_type            early;
   } front_type;

   // saturate sign and magnitude to a 32-bit word
   function automatic sat_type sat_pack(input logic neg, input logic [64:0] mag);
      sat_type r;
      if (!neg) begin
         if (mag > 65'h7fff_ffff) begin
            r.err = 1'b1;
            r.val = MAX_POS;
         end else begin
            r.err = 1'b0;
            r.val = mag[31:0];
         end
      end else begin
         if (mag > 65'h8000_0000) begin
            r.err = 1'b1;
            r.val = MIN_NEG;
         end else begin
            r.err = 1'b0;
            r.val = 32'd0 - mag[31:0];
         end
      end
      return r;
   endfunction

   function automatic sat_type sat_signed(input logic signed [64:0] v);
      logic [64:0] mag;
      mag = v[64] ? $unsigned(-v) : $unsigned(v);
      return sat_pack(v[64], mag);
   endfunction

   // round half away from zero, drop the fraction, saturate
   function automatic sat_type mul_part(input logic signed [64:0] s);
      logic [64:0] mag;
      logic [64:0] rnd;
      mag = s[64] ? $unsigned(-s) : $unsigned(s);
      rnd = (mag + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return sat_pack(s[64], rnd);
   endfunction

   function automatic logic signed [33:0] atan_q30(input int i);
      logic signed [33:0] a;
      case (i)
         0:  a = 34'sd843314857;
         1:  a = 34'sd497837829;
         2:  a = 34'sd263043837;
         3:  a = 34'sd133525159;
         4:  a = 34'sd67021687;
         5:  a = 34'sd33543516;
         6:  a = 34'sd16775851;
         7:  a = 34'sd8388437;
         8:  a = 34'sd4194283;
         9:  a = 34'sd2097149;
         10: a = 34'sd1048576;
         11: a = 34'sd524288;
         12: a = 34'sd262144;
         13: a = 34'sd131072;
         14: a = 34'sd65536;
         15: a = 34'sd32768;
         16: a = 34'sd16384;
         17: a = 34'sd8192;
         18: a = 34'sd4096;
         19: a = 34'sd2048;
         20: a = 34'sd1024;
         21: a = 34'sd512;
         22: a = 34'sd256;
         23: a = 34'sd128;
         24: a = 34'sd64;
         25: a = 34'sd32;
         26: a = 34'sd16;
         27: a = 34'sd8;
         28: a = 34'sd4;
         29: a = 34'sd2;
         30: a = 34'sd1;
         default: a = 34'sd0;
      endcase
      return a;
   endfunction
endpackage

@@ src/complex_arithmetic_unit_core.sv @@
// Complex arithmetic unit, fully pipelined; one word may enter every clock.
// The pipeline depth is set by the divider, one quotient bit per stage.
// Throughput: one word per clock; busy stays low and the receiver cannot stall.
// Reset clears the valid bits only; no clearing pass, no state kept between words.
`timescale 1ns / 1ps
module complex_arithmetic_unit_core import cau_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_res_re,
   output logic signed [31:0] rsp_res_im,
   output logic               rsp_flag,
   output logic               rsp_error
);
   localparam int SQ_PAD = DIV_LAT - SQRT_LAT;
   localparam int CO_PAD = DIV_LAT - CORDIC_LAT;

   front_type   front;
   sat_type     div_re, div_im, root;
   logic [31:0] phase;
   sat_type     m_re, m_im;
   res_type     early_in;
   res_type     early_ff [0:DIV_LAT-1];
   logic        valid_ff [0:DIV_LAT-1];
   logic [2:0]  kind_ff  [0:DIV_LAT-1];
   sat_type     sq_ff    [0:SQ_PAD-1];
   logic [31:0] co_ff    [0:CO_PAD-1];
   res_type     rsp_in, rsp_ff;
   logic        rsp_valid_ff;

   assign busy = 1'b0;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .kind     (req_kind),
      .a_re     (req_a_re),
      .a_im     (req_a_im),
      .b_re     (req_b_re),
      .b_im     (req_b_im),
      .front    (front)
   );

   cau_div u_div_re (
      .clock (clock),
      .n     (front.nre),
      .d     (front.d),
      .quot  (div_re)
   );

   cau_div u_div_im (
      .clock (clock),
      .n     (front.nim),
      .d     (front.d),
      .quot  (div_im)
   );

   cau_sqrt u_sqrt (
      .clock (clock),
      .n     (front.d),
      .root  (root)
   );

   cau_cordic u_cordic (
      .clock (clock),
      .a_re  (front.ar),
      .a_im  (front.ai),
      .phase (phase)
   );

   always_comb begin
      m_re = mul_part(front.mre);
      m_im = mul_part(front.mim);
      if (front.kind == KIND_MUL) begin
         early_in.re   = m_re.val;
         early_in.im   = m_im.val;
         early_in.flag = 1'b0;
         early_in.err  = m_re.err | m_im.err;
      end else begin
         early_in = front.early;
      end
   end

   // line up the short paths with the divider output
   always_ff @(posedge clock) begin
      early_ff[0] <= early_in;
      kind_ff[0]  <= front.kind;
      for (int k = 1; k < DIV_LAT; k++) begin
         early_ff[k] <= early_ff[k-1];
         kind_ff[k]  <= kind_ff[k-1];
      end
      sq_ff[0] <= root;
      for (int k = 1; k < SQ_PAD; k++) begin
         sq_ff[k] <= sq_ff[k-1];
      end
      co_ff[0] <= phase;
      for (int k = 1; k < CO_PAD; k++) begin
         co_ff[k] <= co_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= front.valid;
         for (int k = 1; k < DIV_LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      case (kind_ff[DIV_LAT-1])
         KIND_DIV: begin
            rsp_in.re  = div_re.val;
            rsp_in.im  = div_im.val;
            rsp_in.err = div_re.err | div_im.err;
         end
         KIND_MAG: begin
            rsp_in.re  = sq_ff[SQ_PAD-1].val;
            rsp_in.err = sq_ff[SQ_PAD-1].err;
         end
         KIND_PHASE: rsp_in.re = co_ff[CO_PAD-1];
         default:    rsp_in = early_ff[DIV_LAT-1];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_res_re = rsp_ff.re;
   assign rsp_res_im = rsp_ff.im;
   assign rsp_flag   = rsp_ff.flag;
   assign rsp_error  = rsp_ff.err;
endmodule

@@ src/cau_front.sv @@
// Front end: input register, add/sub/compare, products and product sums.
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [2:0]         kind,
   input  logic signed [31:0] a_re,
   input  logic signed [31:0] a_im,
   input  logic signed [31:0] b_re,
   input  logic signed [31:0] b_im,
   output front_type          front
);
   logic               valid1_ff, valid2_ff, valid3_ff;
   logic [2:0]         kind1_ff, kind2_ff, kind3_ff;
   logic signed [31:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [31:0] ar2_ff, ai2_ff, ar3_ff, ai3_ff;
   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_r_ff, p_bb_i_ff;
   logic signed [64:0] mre_ff, mim_ff, nre_ff, nim_ff;
   logic [63:0]        d_ff;
   res_type            early_in, early2_ff, early3_ff;
   sat_type            s_re, s_im;
   logic               is_less;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   // magnitude reuses the divisor squares, so b takes a's value there
   always_ff @(posedge clock) begin
      kind1_ff <= kind;
      ar1_ff   <= a_re;
      ai1_ff   <= a_im;
      br1_ff   <= (kind == KIND_MAG) ? a_re : b_re;
      bi1_ff   <= (kind == KIND_MAG) ? a_im : b_im;
   end

   always_comb begin
      early_in = '0;
      s_re     = '0;
      s_im     = '0;
      is_less  = (ar1_ff < br1_ff) || ((ar1_ff == br1_ff) && (ai1_ff < bi1_ff));
      case (kind1_ff)
         KIND_ADD: begin
            s_re = sat_signed(65'(ar1_ff) + 65'(br1_ff));
            s_im = sat_signed(65'(ai1_ff) + 65'(bi1_ff));
            early_in.re  = s_re.val;
            early_in.im  = s_im.val;
            early_in.err = s_re.err | s_im.err;
         end
         KIND_SUB: begin
            s_re = sat_signed(65'(ar1_ff) - 65'(br1_ff));
            s_im = sat_signed(65'(ai1_ff) - 65'(bi1_ff));
            early_in.re  = s_re.val;
            early_in.im  = s_im.val;
            early_in.err = s_re.err | s_im.err;
         end
         KIND_EQUAL: early_in.flag = (ar1_ff == br1_ff) && (ai1_ff == bi1_ff);
         KIND_LESS:  early_in.flag = is_less;
         default:    early_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      kind2_ff  <= kind1_ff;
      ar2_ff    <= ar1_ff;
      ai2_ff    <= ai1_ff;
      early2_ff <= early_in;
      p_rr_ff   <= ar1_ff * br1_ff;
      p_ii_ff   <= ai1_ff * bi1_ff;
      p_ri_ff   <= ar1_ff * bi1_ff;
      p_ir_ff   <= ai1_ff * br1_ff;
      p_bb_r_ff <= br1_ff * br1_ff;
      p_bb_i_ff <= bi1_ff * bi1_ff;
   end

   always_ff @(posedge clock) begin
      kind3_ff  <= kind2_ff;
      ar3_ff    <= ar2_ff;
      ai3_ff    <= ai2_ff;
      early3_ff <= early2_ff;
      mre_ff    <= 65'(p_rr_ff) - 65'(p_ii_ff);
      mim_ff    <= 65'(p_ri_ff) + 65'(p_ir_ff);
      nre_ff    <= 65'(p_rr_ff) + 65'(p_ii_ff);
      nim_ff    <= 65'(p_ir_ff) - 65'(p_ri_ff);
      d_ff      <= $unsigned(p_bb_r_ff) + $unsigned(p_bb_i_ff);
   end

   always_comb begin
      front.valid = valid3_ff;
      front.kind  = kind3_ff;
      front.ar    = ar3_ff;
      front.ai    = ai3_ff;
      front.mre   = mre_ff;
      front.mim   = mim_ff;
      front.nre   = nre_ff;
      front.nim   = nim_ff;
      front.d     = d_ff;
      front.early = early3_ff;
   end
endmodule

@@ src/cau_div.sv @@
// Pipelined restoring divider: round(|n| * 2^FRAC_BITS / d) with sign and saturation.
`timescale 1ns / 1ps
module cau_div import cau_pkg::*; (
   input  logic               clock,
   input  logic signed [64:0] n,
   input  logic [63:0]        d,
   output sat_type            quot
);
   logic [63:0]      r_ff   [0:QBITS];
   logic [63:0]      r_in   [0:QBITS];
   logic [QBITS-1:0] low_ff [0:QBITS];
   logic [QBITS-1:0] low_in [0:QBITS];
   logic [QBITS-1:0] q_ff   [0:QBITS];
   logic [QBITS-1:0] q_in   [0:QBITS];
   logic [63:0]      d_ff   [0:QBITS];
   logic [63:0]      d_in   [0:QBITS];
   logic             neg_ff [0:QBITS];
   logic             neg_in [0:QBITS];
   logic             ovf_ff [0:QBITS];
   logic             ovf_in [0:QBITS];
   logic             dz_ff  [0:QBITS];
   logic             dz_in  [0:QBITS];
   logic [64:0]      mag_full;
   logic [63:0]      mag;
   logic             rnd;
   logic [QBITS:0]   q_rnd;
   sat_type          quot_in, quot_ff;

   assign mag_full = n[64] ? $unsigned(-n) : $unsigned(n);
   assign mag      = mag_full[63:0];

   // integer part at or above 2^32 saturates
   assign r_in[0]   = {32'd0, mag[63:32]};
   assign low_in[0] = {mag[31:0], {FRAC_BITS{1'b0}}};
   assign q_in[0]   = '0;
   assign d_in[0]   = d;
   assign neg_in[0] = n[64];
   assign ovf_in[0] = {32'd0, mag[63:32]} >= d;
   assign dz_in[0]  = (d == 64'd0);

   for (genvar k = 0; k < QBITS; k++) begin : g_step
      logic [63:0] sh;
      logic        ge;
      assign sh          = {r_ff[k][62:0], low_ff[k][QBITS-1]};
      assign ge          = sh >= d_ff[k];
      assign r_in[k+1]   = ge ? (sh - d_ff[k]) : sh;
      assign q_in[k+1]   = {q_ff[k][QBITS-2:0], ge};
      assign low_in[k+1] = {low_ff[k][QBITS-2:0], 1'b0};
      assign d_in[k+1]   = d_ff[k];
      assign neg_in[k+1] = neg_ff[k];
      assign ovf_in[k+1] = ovf_ff[k];
      assign dz_in[k+1]  = dz_ff[k];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QBITS; k++) begin
         r_ff[k]   <= r_in[k];
         low_ff[k] <= low_in[k];
         q_ff[k]   <= q_in[k];
         d_ff[k]   <= d_in[k];
         neg_ff[k] <= neg_in[k];
         ovf_ff[k] <= ovf_in[k];
         dz_ff[k]  <= dz_in[k];
      end
   end

   always_comb begin
      rnd   = {r_ff[QBITS], 1'b0} >= {1'b0, d_ff[QBITS]};
      q_rnd = {1'b0, q_ff[QBITS]} + {{QBITS{1'b0}}, rnd};
      if (dz_ff[QBITS]) begin
         quot_in.err = 1'b1;
         quot_in.val = 32'd0;
      end else if (ovf_ff[QBITS]) begin
         quot_in.err = 1'b1;
         quot_in.val = neg_ff[QBITS] ? MIN_NEG : MAX_POS;
      end else begin
         quot_in = sat_pack(neg_ff[QBITS], 65'(q_rnd));
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
endmodule

@@ src/cau_sqrt.sv @@
// Pipelined digit-by-digit square root, rounded to nearest, saturated to 32 bits.
`timescale 1ns / 1ps
module cau_sqrt import cau_pkg::*; (
   input  logic        clock,
   input  logic [63:0] n,
   output sat_type     root
);
   logic [33:0] rem_ff [0:ROOT_STEPS];
   logic [33:0] rem_in [0:ROOT_STEPS];
   logic [31:0] res_ff [0:ROOT_STEPS];
   logic [31:0] res_in [0:ROOT_STEPS];
   logic [63:0] rest_ff [0:ROOT_STEPS];
   logic [63:0] rest_in [0:ROOT_STEPS];
   logic        rnd;
   logic [32:0] res_rnd;
   sat_type     root_in, root_ff;

   assign rem_in[0]  = '0;
   assign res_in[0]  = '0;
   assign rest_in[0] = n;

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
      logic [35:0] sh;
      logic [35:0] trial;
      logic        ge;
      logic [35:0] diff;
      assign sh           = {rem_ff[k], rest_ff[k][63:62]};
      assign trial        = {2'b00, res_ff[k], 2'b01};
      assign ge           = sh >= trial;
      assign diff         = sh - trial;
      assign rem_in[k+1]  = ge ? diff[33:0] : sh[33:0];
      assign res_in[k+1]  = {res_ff[k][30:0], ge};
      assign rest_in[k+1] = {rest_ff[k][61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= ROOT_STEPS; k++) begin
         rem_ff[k]  <= rem_in[k];
         res_ff[k]  <= res_in[k];
         rest_ff[k] <= rest_in[k];
      end
   end

   // remainder above the floor root means the true root is past the half
   always_comb begin
      rnd     = rem_ff[ROOT_STEPS] > {2'b00, res_ff[ROOT_STEPS]};
      res_rnd = {1'b0, res_ff[ROOT_STEPS]} + {32'd0, rnd};
      root_in = sat_pack(1'b0, 65'(res_rnd));
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
   end

   assign root = root_ff;
endmodule

@@ src/cau_cordic.sv @@
// Pipelined vectoring CORDIC: phase angle of a in radians.
`timescale 1ns / 1ps
module cau_cordic import cau_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] a_re,
   input  logic signed [31:0] a_im,
   output logic [31:0]        phase
);
   logic signed [63:0] x_ff    [0:CORDIC_STEPS];
   logic signed [63:0] x_in    [0:CORDIC_STEPS];
   logic signed [63:0] y_ff    [0:CORDIC_STEPS];
   logic signed [63:0] y_in    [0:CORDIC_STEPS];
   logic signed [33:0] z_ff    [0:CORDIC_STEPS];
   logic signed [33:0] z_in    [0:CORDIC_STEPS];
   logic               xneg_ff [0:CORDIC_STEPS];
   logic               xneg_in [0:CORDIC_STEPS];
   logic               yneg_ff [0:CORDIC_STEPS];
   logic               yneg_in [0:CORDIC_STEPS];
   logic               zero_ff [0:CORDIC_STEPS];
   logic               zero_in [0:CORDIC_STEPS];
   logic [31:0]        ux, uy;
   logic signed [35:0] ang;
   logic [35:0]        ang_mag;
   logic [35:0]        ang_rnd;
   logic [31:0]        phase_in, phase_ff;

   // work on |a| in the first quadrant, fold the quadrant back at the end
   assign ux = a_re[31] ? (32'd0 - a_re) : a_re;
   assign uy = a_im[31] ? (32'd0 - a_im) : a_im;
   assign x_in[0]    = {{(32 - CORDIC_PRE){1'b0}}, ux, {CORDIC_PRE{1'b0}}};
   assign y_in[0]    = {{(32 - CORDIC_PRE){1'b0}}, uy, {CORDIC_PRE{1'b0}}};
   assign z_in[0]    = '0;
   assign xneg_in[0] = a_re[31];
   assign yneg_in[0] = a_im[31];
   assign zero_in[0] = (ux == 32'd0) && (uy == 32'd0);

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [63:0] xs, ys;
      assign xs = x_ff[k] >>> k;
      assign ys = y_ff[k] >>> k;
      assign x_in[k+1] = y_ff[k][63] ? (x_ff[k] - ys) : (x_ff[k] + ys);
      assign y_in[k+1] = y_ff[k][63] ? (y_ff[k] + xs) : (y_ff[k] - xs);
      assign z_in[k+1] = y_ff[k][63] ? (z_ff[k] - atan_q30(k)) : (z_ff[k] + atan_q30(k));
      assign xneg_in[k+1] = xneg_ff[k];
      assign yneg_in[k+1] = yneg_ff[k];
      assign zero_in[k+1] = zero_ff[k];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) begin
         x_ff[k]    <= x_in[k];
         y_ff[k]    <= y_in[k];
         z_ff[k]    <= z_in[k];
         xneg_ff[k] <= xneg_in[k];
         yneg_ff[k] <= yneg_in[k];
         zero_ff[k] <= zero_in[k];
      end
   end

   always_comb begin
      ang = xneg_ff[CORDIC_STEPS] ? ($signed(PI_Q30) - 36'(z_ff[CORDIC_STEPS]))
                                  : 36'(z_ff[CORDIC_STEPS]);
      if (yneg_ff[CORDIC_STEPS]) begin
         ang = -ang;
      end
      ang_mag = ang[35] ? $unsigned(-ang) : $unsigned(ang);
      ang_rnd = (ang_mag + (36'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
      if (zero_ff[CORDIC_STEPS]) begin
         phase_in = 32'd0;
      end else begin
         phase_in = ang[35] ? (32'd0 - ang_rnd[31:0]) : ang_rnd[31:0];
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
   end

   assign phase = phase_ff;
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the complex arithmetic unit core.
`timescale 1ns / 1ps

class cau_scoreboard;
   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
      logic        flag;
      logic        err;
   } cau_word_type;

   cau_word_type pending[$];
   int           mismatches;
   int           checked;
   int           kind_seen[8];

   function new();
      mismatches = 0;
      checked    = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
   endfunction

   // clamp a sign/magnitude pair into a 32-bit word
   static function logic [31:0] clamp(bit neg, bit [63:0] mag, ref bit err);
      if (!neg) begin
         if (mag > 64'h7fff_ffff) begin
            err = 1;
            return 32'h7fff_ffff;
         end
         return mag[31:0];
      end
      if (mag > 64'h8000_0000) begin
         err = 1;
         return 32'h8000_0000;
      end
      return 32'd0 - mag[31:0];
   endfunction

   static function logic [31:0] clamp_signed(longint v, ref bit err);
      bit [63:0] mag;
      mag = (v < 0) ? 64'd0 - 64'(v) : 64'(v);
      return clamp(v < 0, mag, err);
   endfunction

   // wrapped 64-bit sum whose true value lies in (-2^63, 2^63]
   static function bit [63:0] split_sign(bit [63:0] s, output bit neg);
      neg = s[63] && (s != 64'h8000_0000_0000_0000);
      return neg ? 64'd0 - s : s;
   endfunction

   static function logic [31:0] product_round(bit [63:0] s, ref bit err);
      bit        neg;
      bit [63:0] mag;
      mag = split_sign(s, neg);
      mag = (mag + 64'd32768) >> 16;
      return clamp(neg, mag, err);
   endfunction

   static function logic [31:0] quotient_round(bit [63:0] s, bit [63:0] d, ref bit err);
      bit        neg;
      bit [63:0] mag, q, r;
      mag = split_sign(s, neg);
      q = mag / d;
      r = mag % d;
      if (q >= 64'h1_0000_0000) begin
         err = 1;
         return neg ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      for (int i = 0; i < 16; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
      if ((r << 1) >= d) q = q + 1;
      return clamp(neg, q, err);
   endfunction

   static function bit [63:0] root_round(bit [63:0] n);
      bit [63:0] rem, res, b;
      rem = n;
      res = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      if (rem > res) res = res + 1;
      return res;
   endfunction

   static function logic [31:0] angle_of(longint xr, longint yr);
      longint    x, y, z, nx, ang;
      bit [63:0] mag;
      bit        neg;
      longint    atan_tbl[20] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                  33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                                  524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                                  2048};
      if (xr == 0 && yr == 0) return 32'd0;
      x = (xr < 0 ? -xr : xr) <<< 28;
      y = (yr < 0 ? -yr : yr) <<< 28;
      z = 0;
      for (int i = 0; i < 20; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_tbl[i];
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_tbl[i];
         end
         x = nx;
      end
      ang = (xr < 0) ? 64'sd3373259426 - z : z;
      if (yr < 0) ang = -ang;
      neg = ang < 0;
      mag = neg ? 64'd0 - 64'(ang) : 64'(ang);
      mag = (mag + 64'd8192) >> 14;
      return neg ? 32'd0 - mag[31:0] : mag[31:0];
   endfunction

   // work out the result of one accepted word and queue it
   function void note_word(logic [2:0] kind, longint ar, longint ai, longint br, longint bi);
      cau_word_type w;
      bit           err;
      bit [63:0]    d;
      err = 0;
      w.re = 0;
      w.im = 0;
      w.flag = 0;
      kind_seen[kind]++;
      case (kind)
         cau_pkg::KIND_ADD: begin
            w.re = clamp_signed(ar + br, err);
            w.im = clamp_signed(ai + bi, err);
         end
         cau_pkg::KIND_SUB: begin
            w.re = clamp_signed(ar - br, err);
            w.im = clamp_signed(ai - bi, err);
         end
         cau_pkg::KIND_MUL: begin
            w.re = product_round(64'(ar * br) - 64'(ai * bi), err);
            w.im = product_round(64'(ar * bi) + 64'(ai * br), err);
         end
         cau_pkg::KIND_DIV: begin
            if (br == 0 && bi == 0) begin
               err = 1;
            end else begin
               d = 64'(br * br) + 64'(bi * bi);
               w.re = quotient_round(64'(ar * br) + 64'(ai * bi), d, err);
               w.im = quotient_round(64'(ai * br) - 64'(ar * bi), d, err);
            end
         end
         cau_pkg::KIND_EQUAL: w.flag = (ar == br && ai == bi);
         cau_pkg::KIND_LESS:  w.flag = (ar < br || (ar == br && ai < bi));
         cau_pkg::KIND_MAG:   w.re = clamp(0, root_round(64'(ar * ar) + 64'(ai * ai)), err);
         default:             w.re = angle_of(ar, ai);
      endcase
      w.err = err;
      pending.push_back(w);
   endfunction

   function void check_word(logic [31:0] re, logic [31:0] im, logic flag, logic err);
      cau_word_type w;
      checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: result word with nothing expected");
         return;
      end
      w = pending.pop_front();
      if (re !== w.re || im !== w.im || flag !== w.flag || err !== w.err) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: exp re=%h im=%h flag=%b err=%b, got re=%h im=%h flag=%b err=%b",
                     w.re, w.im, w.flag, w.err, re, im, flag, err);
      end
   endfunction
endclass

module tb_top;
   import cau_pkg::*;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_kind;
   logic signed [31:0] req_a_re, req_a_im, req_b_re, req_b_im;
   logic               rsp_valid;
   logic signed [31:0] rsp_res_re, rsp_res_im;
   logic               rsp_flag, rsp_error;

   cau_scoreboard sb;
   int            idle_cycles;
   int            idle_pct;

   complex_arithmetic_unit_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_a_re(req_a_re), .req_a_im(req_a_im),
      .req_b_re(req_b_re), .req_b_im(req_b_im),
      .rsp_valid(rsp_valid), .rsp_res_re(rsp_res_re), .rsp_res_im(rsp_res_im),
      .rsp_flag(rsp_flag), .rsp_error(rsp_error)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // scoreboard hooks and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_word(req_kind, req_a_re, req_a_im, req_b_re, req_b_im);
         if (rsp_valid) sb.check_word(rsp_res_re, rsp_res_im, rsp_flag, rsp_error);
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 3000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_word(logic [2:0] k, logic [31:0] ar, logic [31:0] ai,
                            logic [31:0] br, logic [31:0] bi);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 0;
      end
      @(negedge clock);
      start    = 1;
      req_kind = k;
      req_a_re = ar;
      req_a_im = ai;
      req_b_re = br;
      req_b_im = bi;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(5))
         0: return 32'h7fff_ffff - $urandom_range(2);
         1: return 32'h8000_0000 + $urandom_range(2);
         2: return 32'($signed($urandom_range(8)) - 4) <<< $urandom_range(20);
         3: return 32'($signed($urandom_range(200000)) - 100000) <<< 6;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random();
      logic [2:0]  k;
      logic [31:0] ar, ai, br, bi;
      k  = $urandom_range(7);
      ar = pick_operand();
      ai = pick_operand();
      br = pick_operand();
      bi = pick_operand();
      if (k == KIND_EQUAL || k == KIND_LESS) begin
         if ($urandom_range(2) == 0) br = ar;
         if ($urandom_range(2) == 0) bi = ai;
      end
      if (k == KIND_DIV && $urandom_range(9) == 0) begin
         br = 0;
         bi = 0;
      end
      if (k == KIND_PHASE && $urandom_range(5) == 0) ai = 0;
      send_word(k, ar, ai, br, bi);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int pcts[4];
      pcts = '{0, 69, 0, 21};
      sb = new();
      idle_cycles = 0;
      idle_pct = 0;
      reset = 1;
      start = 0;
      req_kind = KIND_ADD;
      req_a_re = 0;
      req_a_im = 0;
      req_b_re = 0;
      req_b_im = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, every kind, special cases
      send_word(KIND_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff);
      send_word(KIND_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_word(KIND_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'hffff_ffff);
      send_word(KIND_SUB, 32'd5, 32'd0, 32'd5, 32'd0);
      send_word(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_word(KIND_MUL, 32'h0001_8000, 32'h0000_8000, 32'h0002_0000, 32'hffff_0000);
      send_word(KIND_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      send_word(KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0);
      send_word(KIND_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'd0);
      send_word(KIND_DIV, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 32'h0002_0000);
      send_word(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_word(KIND_EQUAL, 32'd7, 32'd9, 32'd7, 32'd9);
      send_word(KIND_EQUAL, 32'd7, 32'd9, 32'd7, 32'd8);
      send_word(KIND_LESS, 32'd7, 32'd8, 32'd7, 32'd9);
      send_word(KIND_LESS, 32'h8000_0000, 32'd0, 32'h7fff_ffff, 32'd0);
      send_word(KIND_LESS, 32'd3, 32'd3, 32'd3, 32'd3);
      send_word(KIND_MAG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
      send_word(KIND_MAG, 32'h0003_0000, 32'hfffc_0000, 32'd0, 32'd0);
      send_word(KIND_PHASE, 32'd0, 32'd0, 32'd0, 32'd0);
      send_word(KIND_PHASE, 32'hffff_0000, 32'd0, 32'd0, 32'd0);
      send_word(KIND_PHASE, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0);
      send_word(KIND_PHASE, 32'd0, 32'h7fff_ffff, 32'd0, 32'd0);
      send_word(KIND_PHASE, 32'd1, 32'h8000_0000, 32'd0, 32'd0);
      // hold off until the pipeline has emptied
      drain();

      foreach (pcts[p]) begin
         idle_pct = pcts[p];
         repeat (300) send_random();
      end
      drain();
      repeat (60) @(posedge clock);

      $display("Covered %0d result words: add %0d sub %0d mul %0d div %0d",
               sb.checked, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
      $display("  equal %0d less %0d magnitude %0d phase %0d, idle mixes 0/69/0/21 percent",
               sb.kind_seen[4], sb.kind_seen[5], sb.kind_seen[6], sb.kind_seen[7]);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d words outstanding", sb.mismatches, sb.pending.size());
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

@@ sim.f @@
src/cau_pkg.sv
src/cau_front.sv
src/cau_div.sv
src/cau_sqrt.sv
src/cau_cordic.sv
src/complex_arithmetic_unit_core.sv
tb/tb_top.sv
